### rtl/core/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int CAPACITY    = 32;
    localparam int MAX_RESULTS = 32;
    localparam int SLOT_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);
    localparam int NRES_BITS   = $clog2(MAX_RESULTS + 1);
    localparam int TIME_BITS   = 48;
    localparam int ID_W        = 8;
    localparam int DELAY_W     = 32;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [ID_W-1:0]      owner;
        logic                 live;
    } entry_t;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_CANCEL_RD = 9'b000000010,
        ST_CANCEL_WR = 9'b000000100,
        ST_SCAN_RD   = 9'b000001000,
        ST_SCAN_CMP  = 9'b000010000,
        ST_DECIDE    = 9'b000100000,
        ST_SHIFT_RD  = 9'b001000000,
        ST_SHIFT_WR  = 9'b010000000,
        ST_FLUSH     = 9'b100000000
    } state_t;

endpackage

### rtl/core/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Pending-timer queue in one slot memory, kept in insertion order.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_*      in   tuser = opcode; tdata = timer_id, delay
// m_*      out  tuser = kind;   tdata = fired_id; tlast = final result of item
//
// A start is written in the idle state. A cancel reads each queued entry and
// clears the live flag of those with its id. A tick walks the slot memory: each
// removal runs a minimum search, then closes the gap, via one read, one write port.
// Reset clears the time, the fill count and the output register; slot
// contents are only read below the fill count. A stalled output holds the
// sequencer until the pending result is taken.
// ----------------------------------------------------------------------------
module deadline_timer_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic [39:0] s_tdata,   // [7:0] timer_id, [39:8] delay
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // [0] kind
    output logic [7:0]  m_tdata,   // [7:0] fired_id
    output logic        m_tlast
);

    dtq_pkg::entry_t mem [dtq_pkg::CAPACITY];
    dtq_pkg::entry_t rd_data_reg;
    logic [dtq_pkg::SLOT_BITS-1:0] rd_addr;
    logic                          wr_en;
    logic [dtq_pkg::SLOT_BITS-1:0] wr_addr;
    dtq_pkg::entry_t               wr_data;

    dtq_pkg::state_t state_reg, state_next;
    logic [dtq_pkg::CNT_BITS-1:0]  count_reg, count_next;
    logic [dtq_pkg::CNT_BITS-1:0]  idx_reg, idx_next;
    logic [dtq_pkg::TIME_BITS-1:0] time_reg, time_next;
    logic [dtq_pkg::ID_W-1:0]      cmd_id_reg, cmd_id_next;
    logic                          have_best_reg, have_best_next;
    logic [dtq_pkg::SLOT_BITS-1:0] best_idx_reg, best_idx_next;
    dtq_pkg::entry_t               best_reg, best_next;
    logic [dtq_pkg::NRES_BITS-1:0] nres_reg, nres_next;
    logic                          hold_valid_reg, hold_valid_next;
    logic                          hold_kind_reg, hold_kind_next;
    logic [dtq_pkg::ID_W-1:0]      hold_id_reg, hold_id_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_kind_reg, m_kind_next;
    logic [dtq_pkg::ID_W-1:0]      m_id_reg, m_id_next;
    logic                          m_last_reg, m_last_next;

    logic                          out_free;
    logic [dtq_pkg::CNT_BITS-1:0]  idx_inc;
    logic [dtq_pkg::TIME_BITS:0]   dl_sum;
    logic [dtq_pkg::TIME_BITS-1:0] dl_sat;
    logic [dtq_pkg::ID_W-1:0]      in_id;

    assign s_tready = (state_reg == dtq_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_id_reg;
    assign m_tlast  = m_last_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign idx_inc  = idx_reg + dtq_pkg::CNT_BITS'(1);
    assign in_id    = s_tdata[7:0];
    assign dl_sum   = {1'b0, time_reg}
                    + {{(dtq_pkg::TIME_BITS + 1 - dtq_pkg::DELAY_W){1'b0}}, s_tdata[39:8]};
    // A carry out of the sum means the deadline passed the largest time.
    assign dl_sat   = dl_sum[dtq_pkg::TIME_BITS] ? dtq_pkg::TIME_MAX
                                                 : dl_sum[dtq_pkg::TIME_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        time_next       = time_reg;
        cmd_id_next     = cmd_id_reg;
        have_best_next  = have_best_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        nres_next       = nres_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_id_next    = hold_id_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_kind_next     = m_kind_reg;
        m_id_next       = m_id_reg;
        m_last_next     = m_last_reg;
        rd_addr         = idx_reg[dtq_pkg::SLOT_BITS-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[dtq_pkg::SLOT_BITS-1:0];
        wr_data         = rd_data_reg;

        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        dtq_pkg::OP_START:
                        begin
                            if (count_reg == dtq_pkg::CNT_BITS'(dtq_pkg::CAPACITY))
                            begin
                                hold_valid_next = 1'b1;
                                hold_kind_next  = dtq_pkg::KIND_REJECT;
                                hold_id_next    = in_id;
                                state_next      = dtq_pkg::ST_FLUSH;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = count_reg[dtq_pkg::SLOT_BITS-1:0];
                                wr_data.deadline = dl_sat;
                                wr_data.owner    = in_id;
                                wr_data.live     = 1'b1;
                                count_next       = count_reg + dtq_pkg::CNT_BITS'(1);
                            end
                        end
                        dtq_pkg::OP_CANCEL:
                        begin
                            cmd_id_next = in_id;
                            idx_next    = '0;
                            if (count_reg != '0)
                            begin
                                state_next = dtq_pkg::ST_CANCEL_RD;
                            end
                        end
                        dtq_pkg::OP_TICK:
                        begin
                            if (time_reg != dtq_pkg::TIME_MAX)
                            begin
                                time_next = time_reg + dtq_pkg::TIME_BITS'(1);
                            end
                            nres_next      = '0;
                            idx_next       = '0;
                            have_best_next = 1'b0;
                            state_next     = dtq_pkg::ST_SCAN_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dtq_pkg::ST_CANCEL_RD:
            begin
                state_next = dtq_pkg::ST_CANCEL_WR;
            end
            dtq_pkg::ST_CANCEL_WR:
            begin
                if (rd_data_reg.owner == cmd_id_reg)
                begin
                    wr_en        = 1'b1;
                    wr_data.live = 1'b0;
                end
                idx_next   = idx_inc;
                state_next = (idx_inc == count_reg) ? dtq_pkg::ST_IDLE
                                                    : dtq_pkg::ST_CANCEL_RD;
            end
            dtq_pkg::ST_SCAN_RD:
            begin
                state_next = (idx_reg == count_reg) ? dtq_pkg::ST_DECIDE
                                                    : dtq_pkg::ST_SCAN_CMP;
            end
            dtq_pkg::ST_SCAN_CMP:
            begin
                // Strict compare keeps the oldest slot among equal deadlines.
                if (!have_best_reg || (rd_data_reg.deadline < best_reg.deadline))
                begin
                    best_next     = rd_data_reg;
                    best_idx_next = idx_reg[dtq_pkg::SLOT_BITS-1:0];
                end
                have_best_next = 1'b1;
                idx_next       = idx_inc;
                state_next     = dtq_pkg::ST_SCAN_RD;
            end
            dtq_pkg::ST_DECIDE:
            begin
                if (!have_best_reg || (best_reg.deadline > time_reg)
                    || (best_reg.live && nres_reg == dtq_pkg::NRES_BITS'(dtq_pkg::MAX_RESULTS)))
                begin
                    state_next = hold_valid_reg ? dtq_pkg::ST_FLUSH : dtq_pkg::ST_IDLE;
                end
                else if (!best_reg.live)
                begin
                    idx_next   = {1'b0, best_idx_reg};
                    state_next = dtq_pkg::ST_SHIFT_RD;
                end
                else if (!hold_valid_reg || out_free)
                begin
                    // The previous result is known not to be the final one now.
                    if (hold_valid_reg)
                    begin
                        m_valid_next = 1'b1;
                        m_kind_next  = hold_kind_reg;
                        m_id_next    = hold_id_reg;
                        m_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_kind_next  = dtq_pkg::KIND_FIRED;
                    hold_id_next    = best_reg.owner;
                    nres_next       = nres_reg + dtq_pkg::NRES_BITS'(1);
                    idx_next        = {1'b0, best_idx_reg};
                    state_next      = dtq_pkg::ST_SHIFT_RD;
                end
            end
            dtq_pkg::ST_SHIFT_RD:
            begin
                if (idx_inc >= count_reg)
                begin
                    count_next     = count_reg - dtq_pkg::CNT_BITS'(1);
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    state_next     = dtq_pkg::ST_SCAN_RD;
                end
                else
                begin
                    rd_addr    = idx_inc[dtq_pkg::SLOT_BITS-1:0];
                    state_next = dtq_pkg::ST_SHIFT_WR;
                end
            end
            dtq_pkg::ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = dtq_pkg::ST_SHIFT_RD;
            end
            dtq_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = hold_kind_reg;
                    m_id_next       = hold_id_reg;
                    m_last_next     = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = dtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dtq_pkg::ST_IDLE;
            count_reg      <= '0;
            time_reg       <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            time_reg       <= time_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cmd_id_reg    <= cmd_id_next;
        have_best_reg <= have_best_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        nres_reg      <= nres_next;
        hold_kind_reg <= hold_kind_next;
        hold_id_reg   <= hold_id_next;
        m_kind_reg    <= m_kind_next;
        m_id_reg      <= m_id_next;
        m_last_reg    <= m_last_next;
    end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for deadline_timer_queue. A queue-fed driver offers
// start, cancel, tick and unused-opcode items. A predictor keeps its own copy
// of the timer slots and builds the fired and rejected results each accepted item
// should give. A monitor checks every output transaction against the oldest
// expected result. Both sides idle at random, and the output also holds off
// once for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int DRAIN_CYCLES = 5000;
    localparam int HOLD_CYCLES = 800;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  id;
        logic [31:0] dly;
    } timer_cmd_t;

    typedef struct {
        logic       kind;
        logic [7:0] id;
        logic       last;
    } timer_evt_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tuser;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    deadline_timer_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    timer_cmd_t cmd_q[$];
    timer_evt_t due_q[$];

    // Predicted queue contents, slots kept in insertion order.
    logic [dtq_pkg::TIME_BITS-1:0] slot_deadline[dtq_pkg::CAPACITY];
    logic [7:0]                    slot_owner[dtq_pkg::CAPACITY];
    logic                          slot_live[dtq_pkg::CAPACITY];
    int                            slot_fill;
    logic [dtq_pkg::TIME_BITS-1:0] now_time;

    int  errors;
    int  n_accepted;
    int  n_fired;
    int  n_rejected;
    int  n_ticks;
    int  cycles;
    int  hold_left;
    bit  hold_done;
    bit  s_taken;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic add_event(input logic kind, input logic [7:0] id);
        timer_evt_t e;
        e.kind = kind;
        e.id = id;
        e.last = 1'b0;
        due_q.push_back(e);
    endtask

    task automatic predict_timer(input timer_cmd_t c);
        int best;
        int fired;
        fired = 0;
        case (c.op)
            dtq_pkg::OP_START:
            begin
                if (slot_fill >= dtq_pkg::CAPACITY)
                begin
                    add_event(dtq_pkg::KIND_REJECT, c.id);
                    due_q[$].last = 1'b1;
                    n_rejected++;
                end
                else
                begin
                    if ({16'd0, now_time} + {32'd0, c.dly} > {16'd0, dtq_pkg::TIME_MAX})
                        slot_deadline[slot_fill] = dtq_pkg::TIME_MAX;
                    else
                        slot_deadline[slot_fill] = now_time + {16'd0, c.dly};
                    slot_owner[slot_fill] = c.id;
                    slot_live[slot_fill] = 1'b1;
                    slot_fill++;
                end
            end
            dtq_pkg::OP_CANCEL:
            begin
                for (int i = 0; i < slot_fill; i++)
                    if (slot_owner[i] == c.id)
                        slot_live[i] = 1'b0;
            end
            dtq_pkg::OP_TICK:
            begin
                n_ticks++;
                if (now_time != dtq_pkg::TIME_MAX)
                    now_time++;
                while (slot_fill > 0)
                begin
                    best = 0;
                    for (int i = 1; i < slot_fill; i++)
                        if (slot_deadline[i] < slot_deadline[best])
                            best = i;
                    if (slot_deadline[best] > now_time)
                        break;
                    if (slot_live[best])
                    begin
                        if (fired >= dtq_pkg::MAX_RESULTS)
                            break;
                        add_event(dtq_pkg::KIND_FIRED, slot_owner[best]);
                        fired++;
                    end
                    for (int i = best; i + 1 < slot_fill; i++)
                    begin
                        slot_deadline[i] = slot_deadline[i + 1];
                        slot_owner[i] = slot_owner[i + 1];
                        slot_live[i] = slot_live[i + 1];
                    end
                    slot_fill--;
                end
                if (fired > 0)
                    due_q[$].last = 1'b1;
                n_fired += fired;
            end
            default:
            begin
                // The unused opcode leaves the queue alone.
            end
        endcase
    endtask

    task automatic push_cmd(input logic [1:0] op, input logic [7:0] id,
                            input logic [31:0] dly);
        timer_cmd_t c;
        c.op = op;
        c.id = id;
        c.dly = dly;
        cmd_q.push_back(c);
    endtask

    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 11));
    endfunction

    function automatic logic [31:0] pick_delay();
        if ($urandom_range(0, 99) == 0)
            return $urandom;
        return $urandom_range(0, 8);
    endfunction

    task automatic build_stimulus();
        int total;
        int k;
        // Zero and one-tick delays, extreme ids, a repeated start.
        push_cmd(dtq_pkg::OP_START, 8'h00, 32'd0);
        push_cmd(dtq_pkg::OP_START, 8'hFF, 32'd1);
        push_cmd(dtq_pkg::OP_START, 8'h07, 32'd1);
        push_cmd(dtq_pkg::OP_START, 8'h07, 32'd1);
        push_cmd(dtq_pkg::OP_CANCEL, 8'h99, 32'd0);
        push_cmd(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        push_cmd(dtq_pkg::OP_TICK, 8'h00, 32'd0);
        // A far deadline that is cancelled stays queued but never fires.
        push_cmd(dtq_pkg::OP_START, 8'hA5, 32'hFFFF_FFFF);
        push_cmd(dtq_pkg::OP_CANCEL, 8'hA5, 32'd0);
        push_cmd(dtq_pkg::OP_START, 8'h5A, 32'hAAAA_AAAA);
        push_cmd(dtq_pkg::OP_START, 8'h11, 32'd2);
        push_cmd(dtq_pkg::OP_START, 8'h12, 32'd2);
        push_cmd(dtq_pkg::OP_CANCEL, 8'h11, 32'd0);
        push_cmd(dtq_pkg::OP_START, 8'h13, 32'd1);
        push_cmd(dtq_pkg::OP_TICK, 8'hFF, 32'h5555_5555);
        push_cmd(dtq_pkg::OP_TICK, 8'h00, 32'd0);
        push_cmd(dtq_pkg::OP_TICK, 8'h00, 32'd0);
        total = cmd_q.size();
        while (total < 230)
        begin
            k = $urandom_range(0, 9);
            if (k < 6)
            begin
                repeat ($urandom_range(1, 6))
                    push_cmd(dtq_pkg::OP_START, pick_id(), pick_delay());
                if ($urandom_range(0, 2) == 0)
                    push_cmd(dtq_pkg::OP_CANCEL, pick_id(), $urandom);
                repeat ($urandom_range(1, 8))
                    push_cmd(dtq_pkg::OP_TICK, 8'($urandom), $urandom);
            end
            else if (k < 8)
            begin
                // Run the queue into its full limit, then drain it.
                repeat (dtq_pkg::CAPACITY + 2)
                    push_cmd(dtq_pkg::OP_START, pick_id(), $urandom_range(0, 3));
                repeat (5)
                    push_cmd(dtq_pkg::OP_TICK, 8'd0, 32'd0);
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    push_cmd(2'($urandom), 8'($urandom), pick_delay());
            end
            total = cmd_q.size();
        end
    endtask

    // Sender: changes on the falling edge, takes the next item once the
    // current transaction has completed.
    always @(negedge clk)
    begin
        int idle_pct;
        timer_cmd_t c;
        bit offer;
        if (rst_n)
        begin
            idle_pct = (n_accepted < 77) ? 19 : (n_accepted < 154) ? 48 : 0;
            if (!s_tvalid || s_taken)
            begin
                offer = cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct;
                if (offer)
                begin
                    c = cmd_q.pop_front();
                    s_tuser <= c.op;
                    s_tdata <= {c.dly, c.id};
                end
                s_tvalid <= offer;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off.
    always @(negedge clk)
    begin
        int stall_pct;
        if (rst_n)
        begin
            stall_pct = (n_accepted < 77) ? 48 : (n_accepted < 154) ? 19 : 0;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && n_accepted >= 40)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    // Monitor: predicts on accepted input, checks accepted output.
    always @(posedge clk)
    begin
        timer_cmd_t c;
        timer_evt_t e;
        s_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            c.op = s_tuser;
            c.id = s_tdata[7:0];
            c.dly = s_tdata[39:8];
            predict_timer(c);
            n_accepted <= n_accepted + 1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_q.size() == 0)
            begin
                $error("unexpected result: kind %0d id %0d last %0d",
                       m_tuser, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                e = due_q.pop_front();
                if (m_tuser !== e.kind)
                begin
                    $error("kind: expected %0d, actual %0d", e.kind, m_tuser);
                    errors++;
                end
                if (m_tdata !== e.id)
                begin
                    $error("fired_id: expected %0d, actual %0d", e.id, m_tdata);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last: expected %0d, actual %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("deadline_timer_queue verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        n_accepted = 0;
        n_fired = 0;
        n_rejected = 0;
        n_ticks = 0;
        cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        s_taken = 1'b0;
        slot_fill = 0;
        now_time = '0;
        build_stimulus();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        while (cmd_q.size() > 0 || s_tvalid)
            @(posedge clk);
        while (due_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_q.size() > 0)
        begin
            $error("%0d expected results never arrived", due_q.size());
            errors++;
        end
        $display("covered %0d items, %0d ticks, %0d fired and %0d rejected timers",
                 n_accepted, n_ticks, n_fired, n_rejected);
        if (errors == 0)
            $display("deadline_timer_queue verification clean");
        else
            $display("deadline_timer_queue verification failed");
        $finish;
    end

endmodule
